// ===== design/lrt_pkg.sv =====
// Shared types and codes for the LRU recency tracker.
`timescale 1ns / 1ps

package lrt_pkg;

    localparam int KEY_BITS  = 16;
    localparam int OCC_BITS  = 5;

    // request codes
    localparam logic [1:0] FUNC_TOUCH     = 2'd0;
    localparam logic [1:0] FUNC_EVICT_OLD = 2'd1;
    localparam logic [1:0] FUNC_EVICT_KEY = 2'd2;

    // result status codes
    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_MOVED    = 3'd1;
    localparam logic [2:0] ST_SKIPPED  = 3'd2;
    localparam logic [2:0] ST_EVICTED  = 3'd3;
    localparam logic [2:0] ST_MISS     = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;

    // datapath update operations
    localparam logic [1:0] OP_NONE   = 2'd0;
    localparam logic [1:0] OP_MOVE   = 2'd1;
    localparam logic [1:0] OP_INSERT = 2'd2;
    localparam logic [1:0] OP_DROP   = 2'd3;

    typedef struct packed {
        logic [1:0]          func;
        logic [KEY_BITS-1:0] key;
        logic                is_persistent;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]          status;
        logic [KEY_BITS-1:0] evicted_key;
        logic [OCC_BITS-1:0] occupancy;
    } out_beat_t;

    // controller -> datapath
    typedef struct packed {
        logic       capture;
        logic       look;
        logic       apply;
        logic [1:0] op;
        logic [2:0] status;
    } lrt_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] func;
        logic       pers;
        logic       hit;
        logic       victim;
        logic       free_any;
    } lrt_stat_t;

endpackage

// ===== design/lru_recency_tracker_unit.sv =====
// Top level of the LRU recency tracker: controller plus entry datapath.
`timescale 1ns / 1ps

// LRU recency tracker. Holds up to CAPACITY keys ordered by recency. A touch
// (func 0) inserts a key as most recent or moves a held key to most recent;
// a touch with is_persistent set is skipped, and a touch of a new key while
// full is reported as full and not stored. Evict-oldest (func 1) removes and
// returns the least recent key; evict-key (func 2) removes the named key.
// An evict on an empty tracker or of a key not held reports not found, as
// does the unused code 3. Each request returns exactly one result beat with
// the occupancy after the request. The request is captured when accepted,
// then looked up, then applied in the update state, which writes the result
// beat; a new request is accepted only after the update, so a request is
// not taken while the previous one is still in flight. The lookup
// cycle compares the key against every entry and finds the oldest rank in
// parallel; the update cycle shifts ranks in all entries at once. A result
// beat waits in the output register while the next request is captured and
// looked up; only the update stage stalls on m_ready.
// The entry keys have no reset; valid bits, ranks and count clear on reset.

module lru_recency_tracker_unit #(
    parameter int CAPACITY = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  lrt_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output lrt_pkg::out_beat_t m_data
);
    import lrt_pkg::*;

    lrt_cmd_t  cmd;
    lrt_stat_t stat;

    // sequencing: idle -> lookup -> update, update waits for a free output slot
    lrt_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // entries, parallel match, rank update and output register
    lrt_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_data  (m_data)
    );

endmodule

// ===== design/lrt_datapath.sv =====
// Entry store, parallel key/rank lookup and recency update for the LRU tracker.
`timescale 1ns / 1ps

module lrt_datapath #(
    parameter int CAPACITY = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  lrt_pkg::in_beat_t s_data,
    input  lrt_pkg::lrt_cmd_t cmd,
    output lrt_pkg::lrt_stat_t stat,
    output lrt_pkg::out_beat_t m_data
);
    import lrt_pkg::*;

    localparam int RANK_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    in_beat_t             req_reg;
    logic [KEY_BITS-1:0]  keys_reg [CAPACITY];
    logic [CAPACITY-1:0]  valid_reg, valid_next;
    logic [RANK_W-1:0]    rank_reg [CAPACITY];
    logic [RANK_W-1:0]    rank_next [CAPACITY];
    logic [CNT_W-1:0]     count_reg, count_next;

    logic [CAPACITY-1:0]  sel_vec_reg, free_vec_reg;
    logic [RANK_W-1:0]    sel_rank_reg;
    logic [KEY_BITS-1:0]  sel_key_reg;
    logic                 hit_reg, victim_reg, free_any_reg;
    out_beat_t            out_reg, out_next;

    logic [CAPACITY-1:0]  match, victim, sel, free_vec, first_free;
    logic [RANK_W-1:0]    last_rank, sel_rank;
    logic [KEY_BITS-1:0]  sel_key;

    // lookup over all entries in parallel
    assign last_rank = RANK_W'(count_reg - CNT_W'(1));

    always_comb begin
        sel_rank = '0;
        sel_key  = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            match[i]  = valid_reg[i] && (keys_reg[i] == req_reg.key);
            victim[i] = valid_reg[i] && (rank_reg[i] == last_rank);
        end
        sel = (req_reg.func == FUNC_EVICT_OLD) ? victim : match;
        for (int i = 0; i < CAPACITY; i++) begin
            sel_rank = sel_rank | ({RANK_W{sel[i]}} & rank_reg[i]);
            sel_key  = sel_key  | ({KEY_BITS{sel[i]}} & keys_reg[i]);
        end
        free_vec   = ~valid_reg;
        first_free = free_vec & (~free_vec + CAPACITY'(1));
    end

    // update
    always_comb begin
        valid_next = valid_reg;
        count_next = count_reg;
        for (int i = 0; i < CAPACITY; i++) begin
            rank_next[i] = rank_reg[i];
        end
        if (cmd.apply) begin
            unique case (cmd.op)
                OP_MOVE: begin
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (sel_vec_reg[i]) begin
                            rank_next[i] = '0;
                        end else if (valid_reg[i] && rank_reg[i] < sel_rank_reg) begin
                            rank_next[i] = rank_reg[i] + RANK_W'(1);
                        end
                    end
                end
                OP_INSERT: begin
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (free_vec_reg[i]) begin
                            rank_next[i]  = '0;
                            valid_next[i] = 1'b1;
                        end else if (valid_reg[i]) begin
                            rank_next[i] = rank_reg[i] + RANK_W'(1);
                        end
                    end
                    count_next = count_reg + CNT_W'(1);
                end
                OP_DROP: begin
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (sel_vec_reg[i]) begin
                            rank_next[i]  = '0;
                            valid_next[i] = 1'b0;
                        end else if (valid_reg[i] && rank_reg[i] > sel_rank_reg) begin
                            rank_next[i] = rank_reg[i] - RANK_W'(1);
                        end
                    end
                    count_next = count_reg - CNT_W'(1);
                end
                default: begin
                end
            endcase
        end
        out_next.status      = cmd.status;
        out_next.evicted_key = (cmd.op == OP_DROP) ? sel_key_reg : '0;
        out_next.occupancy   = OCC_BITS'(count_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < CAPACITY; i++) begin
                rank_reg[i] <= '0;
            end
        end else begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            for (int i = 0; i < CAPACITY; i++) begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg <= s_data;
        end
        if (cmd.look) begin
            sel_vec_reg  <= sel;
            sel_rank_reg <= sel_rank;
            sel_key_reg  <= sel_key;
            free_vec_reg <= first_free;
            hit_reg      <= |match;
            victim_reg   <= |victim;
            free_any_reg <= |free_vec;
        end
        if (cmd.apply) begin
            out_reg <= out_next;
            if (cmd.op == OP_INSERT) begin
                for (int i = 0; i < CAPACITY; i++) begin
                    if (free_vec_reg[i]) begin
                        keys_reg[i] <= req_reg.key;
                    end
                end
            end
        end
    end

    assign stat.func     = req_reg.func;
    assign stat.pers     = req_reg.is_persistent;
    assign stat.hit      = hit_reg;
    assign stat.victim   = victim_reg;
    assign stat.free_any = free_any_reg;
    assign m_data        = out_reg;

    // occupancy tracks the valid bits
    a_count_matches_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        CNT_W'($countones(valid_reg)) == count_reg)
        else $error("held count differs from number of valid entries");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("held count above capacity");

endmodule

// ===== design/lrt_controller.sv =====
// Request sequencer and result valid for the LRU tracker.
`timescale 1ns / 1ps

module lrt_controller (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  lrt_pkg::lrt_stat_t stat,
    output lrt_pkg::lrt_cmd_t  cmd
);
    import lrt_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_LOOK  = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       slot_free;
    logic [1:0] op;
    logic [2:0] status;

    assign slot_free = !m_valid_reg || m_ready;

    // decode the lookup flags into an update and a status code
    always_comb begin
        op     = OP_NONE;
        status = ST_MISS;
        unique case (stat.func)
            FUNC_TOUCH: begin
                priority if (stat.pers) begin
                    status = ST_SKIPPED;
                end else if (stat.hit) begin
                    op     = OP_MOVE;
                    status = ST_MOVED;
                end else if (!stat.free_any) begin
                    status = ST_FULL;
                end else begin
                    op     = OP_INSERT;
                    status = ST_INSERTED;
                end
            end
            FUNC_EVICT_OLD: begin
                if (stat.victim) begin
                    op     = OP_DROP;
                    status = ST_EVICTED;
                end
            end
            FUNC_EVICT_KEY: begin
                if (stat.hit) begin
                    op     = OP_DROP;
                    status = ST_EVICTED;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd.capture  = 1'b0;
        cmd.look     = 1'b0;
        cmd.apply    = 1'b0;
        cmd.op       = op;
        cmd.status   = status;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_LOOK;
                end
            end
            S_LOOK: begin
                cmd.look   = 1'b1;
                state_next = S_APPLY;
            end
            S_APPLY: begin
                if (slot_free) begin
                    cmd.apply    = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    // a pending result is never overwritten
    a_apply_needs_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.apply |-> slot_free)
        else $error("result written while previous beat still pending");

    a_stall_holds_apply: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_APPLY && m_valid_reg && !m_ready) |=> state_reg == S_APPLY)
        else $error("update left while output stalled");

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the LRU recency tracker: directed table, then random traffic.
`timescale 1ns / 1ps

module testbench;
    import lrt_pkg::*;

    localparam int DEPTH     = 16;
    localparam int POOL_SIZE = 20;   // a few more keys than entries, so full is reached
    localparam int EPISODE   = 40;   // beats per fill or drain episode
    localparam int PHASE_LEN = 120;  // random beats per idling phase
    localparam int MAX_REPORTS = 200;

    // The package names no constant for the spare request code.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // One directed row: the request, and a hand-written result where one is given.
    typedef struct packed {
        logic      has_exp;
        in_beat_t  req;
        out_beat_t exp;
    } vec_row_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    // Idle/stall odds in percent, changed per phase by the stimulus process.
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    int error_count = 0;
    int beats_sent  = 0;
    int status_seen [6];

    // Expected result beats, oldest first.
    out_beat_t pending_results [$];

    // Shadow copy of the tracker's entries.
    logic [KEY_BITS-1:0] lru_keys [DEPTH];
    logic                lru_live [DEPTH];
    logic [3:0]          lru_rank [DEPTH];
    logic [OCC_BITS-1:0] lru_count;

    always #1 aclk = ~aclk;

    lru_recency_tracker_unit #(
        .CAPACITY(DEPTH)
    ) u_top (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    // Slot holding key k, or -1. Only live slots are compared.
    function automatic int find_slot(input logic [KEY_BITS-1:0] k);
        for (int i = 0; i < DEPTH; i++) begin
            if (lru_live[i] && lru_keys[i] == k) return i;
        end
        return -1;
    endfunction

    // Free a slot; everything older than it moves up one rank.
    function automatic logic [KEY_BITS-1:0] remove_entry(input int slot);
        logic [3:0] r;
        r = lru_rank[slot];
        lru_live[slot] = 1'b0;
        lru_rank[slot] = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (lru_live[i] && lru_rank[i] > r) lru_rank[i] = lru_rank[i] - 4'd1;
        end
        lru_count = lru_count - 5'd1;
        return lru_keys[slot];
    endfunction

    // Apply one request to the shadow entries and return the beat it should produce.
    function automatic out_beat_t predict_recency_update(input in_beat_t req);
        out_beat_t  res;
        int         slot;
        logic [3:0] r;
        res.status      = ST_MISS;
        res.evicted_key = '0;
        slot            = -1;
        case (req.func)
            FUNC_TOUCH: begin
                if (req.is_persistent) begin
                    res.status = ST_SKIPPED;
                end else begin
                    slot = find_slot(req.key);
                    if (slot >= 0) begin
                        // hit: everything younger ages by one, the key becomes newest
                        r = lru_rank[slot];
                        for (int i = 0; i < DEPTH; i++) begin
                            if (lru_live[i] && lru_rank[i] < r) lru_rank[i] = lru_rank[i] + 4'd1;
                        end
                        lru_rank[slot] = '0;
                        res.status = ST_MOVED;
                    end else if (lru_count >= DEPTH) begin
                        res.status = ST_FULL;
                    end else begin
                        for (int i = 0; i < DEPTH; i++) begin
                            if (!lru_live[i]) begin
                                slot = i;
                                break;
                            end
                        end
                        for (int i = 0; i < DEPTH; i++) begin
                            if (lru_live[i]) lru_rank[i] = lru_rank[i] + 4'd1;
                        end
                        lru_keys[slot] = req.key;
                        lru_live[slot] = 1'b1;
                        lru_rank[slot] = '0;
                        lru_count = lru_count + 5'd1;
                        res.status = ST_INSERTED;
                    end
                end
            end
            FUNC_EVICT_OLD: begin
                if (lru_count != 0) begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (lru_live[i] && lru_rank[i] == lru_count - 5'd1) slot = i;
                    end
                    if (slot >= 0) begin
                        res.evicted_key = remove_entry(slot);
                        res.status      = ST_EVICTED;
                    end
                end
            end
            FUNC_EVICT_KEY: begin
                slot = find_slot(req.key);
                if (slot >= 0) begin
                    res.evicted_key = remove_entry(slot);
                    res.status      = ST_EVICTED;
                end
            end
            default: ;  // spare code: nothing changes
        endcase
        res.occupancy = lru_count;
        return res;
    endfunction

    function automatic vec_row_t make_row(input logic [1:0] f, input logic [KEY_BITS-1:0] k,
                                          input logic p, input logic he, input logic [2:0] st,
                                          input logic [KEY_BITS-1:0] ev,
                                          input logic [OCC_BITS-1:0] occ);
        vec_row_t row;
        row.has_exp           = he;
        row.req.func          = f;
        row.req.key           = k;
        row.req.is_persistent = p;
        row.exp.status        = st;
        row.exp.evicted_key   = ev;
        row.exp.occupancy     = occ;
        return row;
    endfunction

    // Present one request, hold it until accepted, then queue what it should return.
    // The predictor always runs so the shadow state follows the block; a typed
    // result, where given, is what gets checked.
    task automatic send_request(input in_beat_t req, input logic has_exp,
                                input out_beat_t exp);
        out_beat_t predicted;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = predict_recency_update(req);
        pending_results.push_back(has_exp ? exp : predicted);
        beats_sent++;
    endtask

    // Result side: random back-pressure and the scoreboard check.
    // Handshake signals are read right after the edge, before any update lands,
    // so they hold their values from the edge itself.
    always @(posedge aclk) begin
        out_beat_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (m_data.status < 3'd6) status_seen[m_data.status]++;
                if (pending_results.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: unexpected result beat %h, nothing pending",
                                 $realtime, m_data);
                end else begin
                    want = pending_results.pop_front();
                    if (m_data.status !== want.status) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("%0t: status expected %0d got %0d",
                                     $realtime, want.status, m_data.status);
                    end
                    if (m_data.evicted_key !== want.evicted_key) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("%0t: evicted_key expected %h got %h",
                                     $realtime, want.evicted_key, m_data.evicted_key);
                    end
                    if (m_data.occupancy !== want.occupancy) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("%0t: occupancy expected %0d got %0d",
                                     $realtime, want.occupancy, m_data.occupancy);
                    end
                end
            end
            m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #400000;
        $display("FAIL lru_recency_tracker_unit");
        $finish;
    end

    initial begin
        vec_row_t            directed_rows [$];
        logic [KEY_BITS-1:0] key_pool [POOL_SIZE];
        in_beat_t            req;
        out_beat_t           no_exp;
        int                  touch_pct;
        int                  roll;
        int                  waited;

        no_exp    = '0;
        lru_count = '0;
        for (int i = 0; i < DEPTH; i++) begin
            lru_keys[i] = '0;
            lru_live[i] = 1'b0;
            lru_rank[i] = '0;
        end
        for (int i = 0; i < 6; i++) status_seen[i] = 0;

        // Directed rows. Empty tracker first: every kind of miss, then a skipped touch.
        directed_rows.push_back(make_row(FUNC_EVICT_OLD, 16'h0000, 1'b0,
                                         1'b1, ST_MISS, 16'h0000, 5'd0));
        directed_rows.push_back(make_row(FUNC_EVICT_KEY, 16'h1234, 1'b0,
                                         1'b1, ST_MISS, 16'h0000, 5'd0));
        directed_rows.push_back(make_row(FUNC_UNUSED, 16'hFFFF, 1'b1,
                                         1'b1, ST_MISS, 16'h0000, 5'd0));
        directed_rows.push_back(make_row(FUNC_TOUCH, 16'hBEEF, 1'b1,
                                         1'b1, ST_SKIPPED, 16'h0000, 5'd0));
        // Key extremes, then a move of a held key.
        directed_rows.push_back(make_row(FUNC_TOUCH, 16'h0000, 1'b0,
                                         1'b1, ST_INSERTED, 16'h0000, 5'd1));
        directed_rows.push_back(make_row(FUNC_TOUCH, 16'hFFFF, 1'b0,
                                         1'b1, ST_INSERTED, 16'h0000, 5'd2));
        directed_rows.push_back(make_row(FUNC_TOUCH, 16'h0000, 1'b0,
                                         1'b1, ST_MOVED, 16'h0000, 5'd2));
        // Persistent flag must be ignored on an evict.
        directed_rows.push_back(make_row(FUNC_EVICT_KEY, 16'hFFFF, 1'b1,
                                         1'b1, ST_EVICTED, 16'hFFFF, 5'd1));
        // Fill to capacity.
        for (int i = 1; i < DEPTH; i++)
            directed_rows.push_back(make_row(FUNC_TOUCH, 16'h5A00 + 16'(i * 37), 1'b0,
                                             1'b0, ST_INSERTED, 16'h0000, 5'd0));
        // New key while full is refused; after an evict-oldest it is not found either.
        directed_rows.push_back(make_row(FUNC_TOUCH, 16'hC3C3, 1'b0,
                                         1'b1, ST_FULL, 16'h0000, 5'd16));
        directed_rows.push_back(make_row(FUNC_EVICT_OLD, 16'h0000, 1'b0,
                                         1'b0, ST_MISS, 16'h0000, 5'd0));
        directed_rows.push_back(make_row(FUNC_EVICT_KEY, 16'hC3C3, 1'b0,
                                         1'b1, ST_MISS, 16'h0000, 5'd15));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].has_exp, directed_rows[i].exp);

        // Random part. Four idling phases: none, sender idle, receiver stall, both.
        // Inside each phase, episodes alternate between filling from a small key
        // pool (so hits, moves and full come up) and draining back toward empty.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 76; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 76; end
                default: begin src_idle_pct = 15; sink_stall_pct = 15; end
            endcase
            for (int n = 0; n < PHASE_LEN; n++) begin
                if (n % (2 * EPISODE) == 0) begin
                    foreach (key_pool[i]) key_pool[i] = KEY_BITS'($urandom_range(0, 65535));
                end
                touch_pct = ((n / EPISODE) % 2 == 0) ? 85 : 25;
                roll = $urandom_range(0, 99);
                req.key           = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                req.is_persistent = ($urandom_range(0, 19) == 0);
                if (roll < touch_pct)
                    req.func = FUNC_TOUCH;
                else if (roll < touch_pct + (100 - touch_pct) / 2)
                    req.func = FUNC_EVICT_OLD;
                else if (roll < 97)
                    req.func = FUNC_EVICT_KEY;
                else
                    req.func = FUNC_UNUSED;
                // occasional stray key from the full range
                if ($urandom_range(0, 19) == 0) req.key = KEY_BITS'($urandom_range(0, 65535));
                send_request(req, 1'b0, no_exp);
            end
        end

        // Last beat was just accepted; drop valid at this same edge.
        s_valid <= 1'b0;

        // Drain: wait for every expected beat, then a few cycles for strays.
        waited = 0;
        while (pending_results.size() != 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (20) @(posedge aclk);
        if (pending_results.size() != 0) begin
            error_count++;
            $display("%0t: %0d result beats never arrived", $realtime, pending_results.size());
        end

        $display("Sent %0d requests across four idling phases; results seen:", beats_sent);
        $display("  inserted %0d, moved %0d, skipped %0d, evicted %0d, miss %0d, full %0d",
                 status_seen[0], status_seen[1], status_seen[2],
                 status_seen[3], status_seen[4], status_seen[5]);
        if (error_count == 0)
            $display("PASS lru_recency_tracker_unit");
        else
            $display("FAIL lru_recency_tracker_unit");
        $finish;
    end

endmodule

// ===== sim.f =====
design/lrt_pkg.sv
design/lrt_datapath.sv
design/lrt_controller.sv
design/lru_recency_tracker_unit.sv
bench/testbench.sv
